>>> hdl/gsdt_pkg.sv
package gsdt_pkg;

  localparam int ID_W = 19;
  localparam int WORD_W = ID_W + 2;
  localparam logic [ID_W-1:0] ID_MAX = '1;

  typedef enum logic [1:0] {
    MODE_CENTROID   = 2'd0,
    MODE_BATCH      = 2'd1,
    MODE_SAMPLE     = 2'd2,
    MODE_INVALIDATE = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  keep;
    logic  err;
  } item_ctl_t;

  localparam int CTL_W = $bits(item_ctl_t);

endpackage

>>> hdl/gsdt_ram.sv
module gsdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/gsdt_front.sv
module gsdt_front
  import gsdt_pkg::*;
#(
  parameter int CAP_PER_DIM = 65,
  parameter int CELLS = 274625,
  parameter int GID_W = 19,
  parameter int PW = 13
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   busy,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mode_t                  in_mode,
  input  logic [6:0]             in_x,
  input  logic [6:0]             in_y,
  input  logic [6:0]             in_z,
  input  logic [ID_W-1:0]        in_target,
  input  logic                   in_keep,
  output logic                   push,
  input  logic                   push_ready,
  output item_ctl_t              push_ctl,
  output logic [GID_W-1:0]       push_gid
);

  logic              v1;
  item_ctl_t         ctl1;
  logic [PW-1:0]     p1;
  logic [6:0]        z1;
  logic [ID_W-1:0]   target1;
  logic              accept;
  logic              coord_err;

  assign in_ready = !busy && (!v1 || push_ready);
  assign accept = in_valid && in_ready;
  assign push = v1 && push_ready;

  assign coord_err = (32'(in_x) >= CAP_PER_DIM) || (32'(in_y) >= CAP_PER_DIM) ||
                     (32'(in_z) >= CAP_PER_DIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (push) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl1.mode <= in_mode;
      ctl1.keep <= in_keep;
      case (in_mode)
        MODE_BATCH:      ctl1.err <= 1'b0;
        MODE_INVALIDATE: ctl1.err <= 32'(in_target) >= CELLS;
        default:         ctl1.err <= coord_err;
      endcase
      p1 <= PW'(32'(in_x) * CAP_PER_DIM + 32'(in_y));
      z1 <= in_z;
      target1 <= in_target;
    end
  end

  assign push_ctl = ctl1;
  assign push_gid = (ctl1.mode == MODE_INVALIDATE) ? GID_W'(target1)
                                                   : GID_W'(32'(p1) * CAP_PER_DIM + 32'(z1));

endmodule

>>> hdl/gsdt_queue.sv
module gsdt_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign push_ready = count != 2'd2;
  assign pop_valid = count != 2'd0;
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && pop_valid) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push && push_ready, pop && pop_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

>>> hdl/gsdt_back.sv
module gsdt_back
  import gsdt_pkg::*;
#(
  parameter int CELLS = 274625,
  parameter int GID_W = 19
) (
  input  logic             clk,
  input  logic             rst,
  output logic             busy,
  input  logic             q_valid,
  output logic             q_pop,
  input  item_ctl_t        q_ctl,
  input  logic [GID_W-1:0] q_gid,
  output logic             ram_we,
  output logic [GID_W-1:0] ram_waddr,
  output logic [WORD_W-1:0] ram_wdata,
  output logic             ram_re,
  output logic [GID_W-1:0] ram_raddr,
  input  logic [WORD_W-1:0] ram_rdata,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ID_W-1:0]  out_grid_id,
  output logic [ID_W-1:0]  out_sample_id,
  output logic             out_is_new,
  output logic             out_proj_added,
  output logic             out_range_error
);

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_IDLE  = 3'b010,
    B_READ  = 3'b100
  } back_state_t;

  localparam logic [GID_W-1:0] LAST_ADDR = GID_W'(CELLS - 1);

  back_state_t      state;
  back_state_t      state_next;
  logic [GID_W-1:0] clr_addr;
  item_ctl_t        cur_ctl;
  logic [GID_W-1:0] cur_gid;
  logic [ID_W-1:0]  centroid_count;
  logic [ID_W-1:0]  centroid_count_next;
  logic [ID_W-1:0]  batch_count;
  logic [ID_W-1:0]  batch_count_next;
  logic             out_free;
  logic             take;
  logic             direct;
  logic             rd_exist;
  logic             rd_proj;
  logic [ID_W-1:0]  rd_sid;
  logic             wr_exist;
  logic             wr_proj;
  logic [ID_W-1:0]  wr_sid;
  logic [ID_W-1:0]  res_sid;
  logic             res_new;
  logic             res_added;
  logic [ID_W:0]    sum;
  logic [ID_W-1:0]  sum_sat;
  logic [ID_W-1:0]  cc_inc;
  logic [ID_W-1:0]  bc_inc;

  assign busy = state == B_CLEAR;
  assign out_free = !out_valid || out_ready;
  assign take = (state == B_IDLE) && q_valid && out_free;
  assign direct = q_ctl.err || (q_ctl.mode == MODE_BATCH);
  assign q_pop = take;

  assign ram_re = take && !direct;
  assign ram_raddr = q_gid;

  assign rd_exist = ram_rdata[0];
  assign rd_proj = ram_rdata[1];
  assign rd_sid = ram_rdata[WORD_W-1:2];

  assign sum = {1'b0, centroid_count} + {1'b0, batch_count};
  assign sum_sat = sum[ID_W] ? ID_MAX : sum[ID_W-1:0];
  assign cc_inc = (centroid_count == ID_MAX) ? centroid_count : centroid_count + 1'b1;
  assign bc_inc = (batch_count == ID_MAX) ? batch_count : batch_count + 1'b1;

  always_comb begin
    wr_exist = rd_exist;
    wr_proj = rd_proj;
    wr_sid = rd_sid;
    res_new = 1'b0;
    res_added = 1'b0;
    centroid_count_next = centroid_count;
    batch_count_next = batch_count;
    case (cur_ctl.mode)
      MODE_CENTROID: begin
        wr_exist = 1'b1;
        wr_sid = centroid_count;
        res_new = !rd_exist;
        centroid_count_next = cc_inc;
      end
      MODE_SAMPLE: begin
        wr_exist = 1'b1;
        wr_proj = 1'b1;
        res_added = !rd_proj;
        if (!rd_exist) begin
          wr_sid = sum_sat;
          res_new = 1'b1;
          batch_count_next = bc_inc;
        end
      end
      MODE_INVALIDATE: begin
        if (!cur_ctl.keep) begin
          wr_proj = 1'b0;
        end
      end
      default: begin
        wr_exist = rd_exist;
      end
    endcase
    res_sid = wr_exist ? wr_sid : '0;
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = cur_gid;
    ram_wdata = {wr_sid, wr_proj, wr_exist};
    if (state == B_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == B_READ) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    case (state)
      B_CLEAR: state_next = (clr_addr == LAST_ADDR) ? B_IDLE : B_CLEAR;
      B_IDLE:  state_next = (take && !direct) ? B_READ : B_IDLE;
      B_READ:  state_next = B_IDLE;
      default: state_next = B_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr_addr <= '0;
      centroid_count <= '0;
      batch_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == B_READ) begin
        centroid_count <= centroid_count_next;
        batch_count <= batch_count_next;
      end else if (take && !q_ctl.err && (q_ctl.mode == MODE_BATCH)) begin
        batch_count <= '0;
      end
      if ((take && direct) || (state == B_READ)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_ctl <= q_ctl;
      cur_gid <= q_gid;
    end
    if (take && direct) begin
      out_grid_id <= '0;
      out_sample_id <= '0;
      out_is_new <= 1'b0;
      out_proj_added <= 1'b0;
      out_range_error <= q_ctl.err;
    end else if (state == B_READ) begin
      out_grid_id <= ID_W'(cur_gid);
      out_sample_id <= res_sid;
      out_is_new <= res_new;
      out_proj_added <= res_added;
      out_range_error <= 1'b0;
    end
  end

endmodule

>>> hdl/grid_sample_dedup_table_core.sv
// The block takes one command per transfer on the s_axis channel: the mode in
// tuser and the coordinates, target id and keep flag in tdata. Each command
// gives exactly one result transfer on the m_axis channel, in command order.
// A front stage checks ranges and linearizes the coordinates, a two-entry
// queue decouples it from the back end, which does a read-modify-write of
// one word per grid id in a single memory holding the existing bit, the
// projection bit and the sample id.
// A command that touches the memory takes a read and a write on the memory
// port: the back end issues the read from the idle state and the write from
// the read state, and takes no new item before the write; batch starts and
// out-of-range commands are answered straight from the idle state.
// After reset the back end clears the memory, one entry per cycle, for all
// CAP_PER_DIM cubed cells (274625 at the default); s_axis_tready stays low
// during that pass. A stalled result is held in the output register while
// the front stage and the queue keep taking commands until they fill up.
module grid_sample_dedup_table_core
  import gsdt_pkg::*;
#(
  parameter int CAP_PER_DIM = 65
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: x[6:0], y[13:7], z[20:14], target_id[39:21],
  // keep_valid[40], zero fill to 48 bits.
  input  logic [47:0] s_axis_tdata,
  // Fields from bit 0: mode[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: grid_id[18:0], sample_id[37:19], zero fill to 40 bits.
  output logic [39:0] m_axis_tdata,
  // Fields from bit 0: is_new[0], proj_added[1], range_error[2].
  output logic [2:0]  m_axis_tuser
);

  localparam int CELLS = CAP_PER_DIM * CAP_PER_DIM * CAP_PER_DIM;
  localparam int GID_W = $clog2(CELLS);
  localparam int PW = $clog2(CAP_PER_DIM * CAP_PER_DIM);
  localparam int QW = CTL_W + GID_W;

  logic             busy;
  logic             push;
  logic             push_ready;
  item_ctl_t        push_ctl;
  logic [GID_W-1:0] push_gid;
  logic             q_valid;
  logic             q_pop;
  logic [QW-1:0]    q_data;
  item_ctl_t        q_ctl;
  logic [GID_W-1:0] q_gid;
  logic             ram_we;
  logic [GID_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic             ram_re;
  logic [GID_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [ID_W-1:0]  grid_id;
  logic [ID_W-1:0]  sample_id;
  logic             is_new;
  logic             proj_added;
  logic             range_error;

  gsdt_front #(
    .CAP_PER_DIM(CAP_PER_DIM),
    .CELLS(CELLS),
    .GID_W(GID_W),
    .PW(PW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .busy(busy),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_mode(mode_t'(s_axis_tuser)),
    .in_x(s_axis_tdata[6:0]),
    .in_y(s_axis_tdata[13:7]),
    .in_z(s_axis_tdata[20:14]),
    .in_target(s_axis_tdata[39:21]),
    .in_keep(s_axis_tdata[40]),
    .push(push),
    .push_ready(push_ready),
    .push_ctl(push_ctl),
    .push_gid(push_gid)
  );

  gsdt_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_ready(push_ready),
    .push_data({push_ctl, push_gid}),
    .pop(q_pop),
    .pop_valid(q_valid),
    .pop_data(q_data)
  );

  assign q_ctl = item_ctl_t'(q_data[QW-1:GID_W]);
  assign q_gid = q_data[GID_W-1:0];

  gsdt_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  gsdt_back #(
    .CELLS(CELLS),
    .GID_W(GID_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .busy(busy),
    .q_valid(q_valid),
    .q_pop(q_pop),
    .q_ctl(q_ctl),
    .q_gid(q_gid),
    .ram_we(ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re(ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_grid_id(grid_id),
    .out_sample_id(sample_id),
    .out_is_new(is_new),
    .out_proj_added(proj_added),
    .out_range_error(range_error)
  );

  assign m_axis_tdata = {2'b00, sample_id, grid_id};
  assign m_axis_tuser = {range_error, proj_added, is_new};

endmodule

>>> hdl/gsdt_checker.sv
module gsdt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic       in_xfer;
  logic       out_xfer;
  logic [3:0] pending;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {3'b000, in_xfer} - {3'b000, out_xfer};
    end
  end

  a_out_has_cause: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 4'd0)
    else $error("result transfer offered with no command outstanding");

  a_error_result_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata == 40'd0 && m_axis_tuser[1:0] == 2'b00))
    else $error("range error result carries ids or flags");

  a_no_input_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("command accepted before the memory clear finished");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind grid_sample_dedup_table_core gsdt_checker u_checker (.*);
